// File: design/foe_pkg.sv
// Shared constants, codes and types of the frame orientation engine.
package foe_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int DIM_W  = 9;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int CFG_W  = DIM_W;
    localparam int IDX_W  = 2;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_TRANSFORM_MODE = 2'd2,
        CFG_SWAP_CHANNELS  = 2'd3
    } foe_cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_COPY   = 2'd0,
        MODE_VFLIP  = 2'd1,
        MODE_MIRROR = 2'd2,
        MODE_DECIM  = 2'd3
    } foe_mode_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        foe_mode_t        mode;
        logic             swap;
    } foe_cfg_t;

    typedef struct packed {
        logic              write;
        logic              read;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
        logic              last;
    } foe_mem_req_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: design/foe_cmd_if.sv
// Command channel: load or fetch commands with the pixel to be loaded.
interface foe_cmd_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_first;
    logic [7:0] in_second;
    logic [7:0] in_third;

    modport source (output valid, command, in_first, in_second, in_third, input ready);
    modport sink   (input valid, command, in_first, in_second, in_third, output ready);
endinterface

// File: design/foe_rsp_if.sv
// Response channel: one output pixel per fetch command.
interface foe_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
    logic       frame_end;

    modport source (output valid, out_first, out_second, out_third, frame_end, input ready);
    modport sink   (input valid, out_first, out_second, out_third, frame_end, output ready);
endinterface

// File: design/foe_frame_ram.sv
// Frame store: single-port synchronous RAM with registered read data.
module foe_frame_ram
(
    input  logic                         clk,
    input  foe_pkg::foe_mem_req_t        req,
    output logic [foe_pkg::PIX_W-1:0]    rdata
);
    import foe_pkg::*;

    logic [PIX_W-1:0] store_mem [MAX_WIDTH * MAX_HEIGHT];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.write)
        begin
            store_mem[req.addr] <= req.wdata;
        end
        if (req.read)
        begin
            rdata_reg <= store_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/foe_sequencer.sv
// Load and fetch counters and the frame store address for each command.
module foe_sequencer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  foe_pkg::foe_cfg_t             cfg,
    input  logic                          accept,
    input  logic                          command,
    input  logic [foe_pkg::CHAN_W-1:0]    in_first,
    input  logic [foe_pkg::CHAN_W-1:0]    in_second,
    input  logic [foe_pkg::CHAN_W-1:0]    in_third,
    output foe_pkg::foe_mem_req_t         req
);
    import foe_pkg::*;

    logic [ADDR_W-1:0]        load_pos_reg, load_pos_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [COL_W-1:0]         col_reg, col_next;

    logic [2*DIM_W-1:0]       total;
    logic [ADDR_W-1:0]        pos_eff;
    logic [ADDR_W:0]          pos_inc;
    logic [DIM_W-1:0]         ow, oh;
    logic [DIM_W-1:0]         row_e, col_e;
    logic                     restart;
    logic [DIM_W-1:0]         sr_w, sc_w;
    logic [ROW_W+DIM_W-1:0]   row_base;
    logic [ROW_W+DIM_W:0]     addr_sum;
    logic                     last;
    logic [PIX_W-1:0]         wdata;

    always_comb
    begin
        total   = {{DIM_W{1'b0}}, cfg.width} * {{DIM_W{1'b0}}, cfg.height};
        pos_eff = ((2*DIM_W)'(load_pos_reg) >= total) ? '0 : load_pos_reg;
        pos_inc = {1'b0, pos_eff} + (ADDR_W+1)'(1);

        if (cfg.mode == MODE_DECIM)
        begin
            ow = (cfg.width + DIM_W'(1)) >> 1;
            oh = (cfg.height + DIM_W'(1)) >> 1;
        end
        else
        begin
            ow = cfg.width;
            oh = cfg.height;
        end

        restart = (DIM_W'(row_reg) >= oh) || (DIM_W'(col_reg) >= ow);
        row_e   = restart ? '0 : DIM_W'(row_reg);
        col_e   = restart ? '0 : DIM_W'(col_reg);

        case (cfg.mode)
            MODE_VFLIP:
            begin
                sr_w = cfg.height - DIM_W'(1) - row_e;
                sc_w = col_e;
            end
            MODE_MIRROR:
            begin
                sr_w = row_e;
                sc_w = cfg.width - DIM_W'(1) - col_e;
            end
            MODE_DECIM:
            begin
                sr_w = row_e << 1;
                sc_w = col_e << 1;
            end
            default:
            begin
                sr_w = row_e;
                sc_w = col_e;
            end
        endcase

        row_base = sr_w[ROW_W-1:0] * cfg.width;
        addr_sum = {1'b0, row_base} + (ROW_W+DIM_W+1)'(sc_w);
        last     = (row_e == oh - DIM_W'(1)) && (col_e == ow - DIM_W'(1));

        if (cfg.swap)
        begin
            wdata = {in_third, in_second, in_first};
        end
        else
        begin
            wdata = {in_first, in_second, in_third};
        end

        load_pos_next = load_pos_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        if (accept && (command == CMD_LOAD))
        begin
            load_pos_next = ((2*DIM_W)'(pos_inc) >= total) ? '0 : pos_inc[ADDR_W-1:0];
        end
        if (accept && (command == CMD_FETCH))
        begin
            if (col_e + DIM_W'(1) >= ow)
            begin
                col_next = '0;
                row_next = (row_e + DIM_W'(1) >= oh) ? '0 : ROW_W'(row_e + DIM_W'(1));
            end
            else
            begin
                col_next = COL_W'(col_e + DIM_W'(1));
                row_next = row_e[ROW_W-1:0];
            end
        end

        req.write = accept && (command == CMD_LOAD);
        req.read  = accept && (command == CMD_FETCH);
        req.addr  = (command == CMD_LOAD) ? pos_eff : addr_sum[ADDR_W-1:0];
        req.wdata = wdata;
        req.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            load_pos_reg <= load_pos_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

endmodule

// File: design/frame_orientation_engine_core.sv
// Top level of the frame orientation engine: configuration, handshakes, output register.
//
//   Channel   Direction  Moves per transfer
//   cmd       sink       command, in_first, in_second, in_third
//   rsp       source     out_first, out_second, out_third, frame_end
//   cfg_*     write      cfg_index selects the register, cfg_data carries the value
//
// A load writes the frame store on transfer; a fetch leaves a read in flight in the
// single-port frame store, during which no new command is taken.
// Reset clears the counters and the output valid flag and returns the
// configuration to its defaults; the frame store is not cleared and holds
// garbage until loaded.
// A response that waits on rsp.ready stalls the command channel.
module frame_orientation_engine_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [foe_pkg::IDX_W-1:0]    cfg_index,
    input  logic [foe_pkg::CFG_W-1:0]    cfg_data,
    foe_cmd_if.sink                      cmd,
    foe_rsp_if.source                    rsp
);
    import foe_pkg::*;

    // Configuration registers. Dimensions are clamped to the legal range on
    // the way in, so the rest of the design only ever sees 1..MAX values.
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    foe_mode_t        mode_reg, mode_next;
    logic             swap_reg, swap_next;
    foe_cfg_t         cfg;

    // A fetch transfer leaves a read in flight; the pixel then lands in the
    // output register together with its end-of-frame flag.
    logic             pend_reg, pend_next;
    logic             last_pend_reg, last_pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg, out_pix_next;
    logic             frame_end_reg, frame_end_next;

    logic             cmd_accept;
    foe_mem_req_t     mem_req;
    logic [PIX_W-1:0] mem_rdata;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        swap_next   = swap_reg;
        if (cfg_we)
        begin
            case (foe_cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:    width_next  = clamp_dim(cfg_data, MAX_W_DIM);
                CFG_FRAME_HEIGHT:   height_next = clamp_dim(cfg_data, MAX_H_DIM);
                CFG_TRANSFORM_MODE: mode_next   = foe_mode_t'(cfg_data[1:0]);
                CFG_SWAP_CHANNELS:  swap_next   = cfg_data[0];
                default:            width_next  = width_reg;
            endcase
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.mode   = mode_reg;
    assign cfg.swap   = swap_reg;

    // Take a command only when no read is in flight and the output register
    // is free, or is being emptied in this same cycle.
    assign cmd.ready  = !pend_reg && (!out_valid_reg || rsp.ready);
    assign cmd_accept = cmd.valid && cmd.ready;

    foe_sequencer u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (cmd_accept),
        .command   (cmd.command),
        .in_first  (cmd.in_first),
        .in_second (cmd.in_second),
        .in_third  (cmd.in_third),
        .req       (mem_req)
    );

    foe_frame_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        pend_next      = mem_req.read;
        last_pend_next = mem_req.read ? mem_req.last : last_pend_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        frame_end_next = frame_end_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = mem_rdata;
            frame_end_next = last_pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= MAX_W_DIM;
            height_reg    <= MAX_H_DIM;
            mode_reg      <= MODE_COPY;
            swap_reg      <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            mode_reg      <= mode_next;
            swap_reg      <= swap_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_pend_reg <= last_pend_next;
        out_pix_reg   <= out_pix_next;
        frame_end_reg <= frame_end_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_first  = out_pix_reg[PIX_W-1 -: CHAN_W];
    assign rsp.out_second = out_pix_reg[2*CHAN_W-1 -: CHAN_W];
    assign rsp.out_third  = out_pix_reg[CHAN_W-1:0];
    assign rsp.frame_end  = frame_end_reg;

`ifndef SYNTHESIS
    // A fetch transfer must leave exactly one read in flight.
    a_fetch_pends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd.command == CMD_FETCH)) |=> pend_reg)
        else $error("fetch transfer did not start a frame store read");

    // A load transfer produces no response.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd.command == CMD_LOAD)) |=> !pend_reg)
        else $error("load transfer started a read");

    // While a read is in flight the output register is empty, so no pixel is lost.
    a_pend_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("read returned into an occupied output register");

    // Each completed read shows up as a valid response in the next cycle.
    a_pend_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> rsp.valid)
        else $error("completed read did not reach the output");
`endif

endmodule

// File: verif/frame_orientation_engine_core_tb.sv
// Testbench for frame_orientation_engine_core: directed and random frames, checked against a model.
module frame_orientation_engine_core_tb;
    import foe_pkg::*;

    // One output pixel as the response channel carries it.
    typedef struct packed {
        logic [CHAN_W-1:0] first;
        logic [CHAN_W-1:0] second;
        logic [CHAN_W-1:0] third;
        logic              frame_end;
    } out_pixel_t;

    localparam int unsigned STORE_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    // Quiet cycles that cover any load or fetch still in flight.
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned END_WAIT_LIMIT = 20000;
    localparam int unsigned RANDOM_ITEMS   = 1075;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    foe_cmd_if cmd_ch ();
    foe_rsp_if rsp_ch ();

    frame_orientation_engine_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Our own picture of the block: the frame image, the registers as written
    // (raw, with out-of-range sizes clamped at use where the block clamps on write)
    // and the load and output counters.
    logic [PIX_W-1:0] frame_image [STORE_DEPTH];
    bit               pixel_loaded [STORE_DEPTH];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    foe_mode_t        mode_reg;
    logic             swap_reg;
    int unsigned      next_load_addr;
    int unsigned      next_out_row;
    int unsigned      next_out_col;

    // Output pixels still owed by the block, oldest first.
    out_pixel_t       pending_pixels [$];

    int unsigned      error_count;
    int unsigned      load_count;
    int unsigned      fetch_count;
    int unsigned      checked_count;
    int unsigned      frame_end_count;
    int unsigned      phase_count;

    // Random idling on both channels; cleared for the last part of the run.
    bit               idle_enabled;
    // Set by a test to make the receiver hold ready low for this many cycles.
    int unsigned      rsp_hold_cycles;

    function automatic int unsigned clip_dim(logic [DIM_W-1:0] raw, int unsigned limit);
        if (raw == '0)
        begin
            return 1;
        end
        if (raw > limit)
        begin
            return limit;
        end
        return raw;
    endfunction

    function automatic int unsigned frame_total();
        return clip_dim(width_reg, MAX_WIDTH) * clip_dim(height_reg, MAX_HEIGHT);
    endfunction

    // Number of pixels in one output frame under the current mode.
    function automatic int unsigned output_count();
        int unsigned w;
        int unsigned h;
        w = clip_dim(width_reg, MAX_WIDTH);
        h = clip_dim(height_reg, MAX_HEIGHT);
        if (mode_reg == MODE_DECIM)
        begin
            return ((w + 1) / 2) * ((h + 1) / 2);
        end
        return w * h;
    endfunction

    // True when every address of the current frame has been loaded at least
    // once, so that no fetch can touch a pixel that was never written.
    function automatic bit frame_covered();
        int unsigned total;
        total = frame_total();
        for (int unsigned i = 0; i < total; i++)
        begin
            if (!pixel_loaded[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Applies one accepted command to the frame picture; a fetch queues the
    // pixel the block must return for it.
    function automatic void track_command(logic command, logic [7:0] a, logic [7:0] b,
                                          logic [7:0] c);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned ow;
        int unsigned oh;
        int unsigned src_row;
        int unsigned src_col;
        int unsigned addr;
        logic [7:0]  tmp;
        out_pixel_t  px;
        w = clip_dim(width_reg, MAX_WIDTH);
        h = clip_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        if (command == CMD_LOAD)
        begin
            // A load position left outside a shrunken frame starts over at zero.
            addr = (next_load_addr >= total) ? 0 : next_load_addr;
            if (swap_reg)
            begin
                tmp = a;
                a = c;
                c = tmp;
            end
            frame_image[addr] = {a, b, c};
            pixel_loaded[addr] = 1'b1;
            next_load_addr = (addr + 1 >= total) ? 0 : addr + 1;
            load_count++;
        end
        else
        begin
            ow = w;
            oh = h;
            if (mode_reg == MODE_DECIM)
            begin
                ow = (w + 1) / 2;
                oh = (h + 1) / 2;
            end
            // Output counters outside the output frame restart the frame.
            if (next_out_row >= oh || next_out_col >= ow)
            begin
                next_out_row = 0;
                next_out_col = 0;
            end
            case (mode_reg)
                MODE_VFLIP:
                begin
                    src_row = h - 1 - next_out_row;
                    src_col = next_out_col;
                end
                MODE_MIRROR:
                begin
                    src_row = next_out_row;
                    src_col = w - 1 - next_out_col;
                end
                MODE_DECIM:
                begin
                    src_row = 2 * next_out_row;
                    src_col = 2 * next_out_col;
                end
                default:
                begin
                    src_row = next_out_row;
                    src_col = next_out_col;
                end
            endcase
            {px.first, px.second, px.third} = frame_image[src_row * w + src_col];
            px.frame_end = (next_out_row == oh - 1) && (next_out_col == ow - 1);
            pending_pixels.push_back(px);
            if (next_out_col + 1 >= ow)
            begin
                next_out_col = 0;
                next_out_row = (next_out_row + 1 >= oh) ? 0 : next_out_row + 1;
            end
            else
            begin
                next_out_col++;
            end
            fetch_count++;
        end
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one command and returns in the time step of its transfer, with
    // valid still high so that the next command can follow back to back.
    task automatic send_command(logic command, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= command;
        cmd_ch.in_first  <= a;
        cmd_ch.in_second <= b;
        cmd_ch.in_third  <= c;
        do
        begin
            @(posedge clk);
        end
        while (cmd_ch.ready !== 1'b1);
        track_command(command, a, b, c);
    endtask

    task automatic send_load(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        send_command(CMD_LOAD, a, b, c);
    endtask

    // The pixel fields of a fetch are ignored, so they carry random bytes.
    task automatic send_fetch();
        send_command(CMD_FETCH, random_byte(), random_byte(), random_byte());
    endtask

    // Loads one whole frame of random pixels at the current size.
    task automatic load_frame();
        int unsigned total;
        total = frame_total();
        repeat (total) send_load(random_byte(), random_byte(), random_byte());
    endtask

    // Stops offering commands and waits until every output pixel has come
    // back and the last load has had time to land in the frame store.
    task automatic wait_for_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are only written while the block is idle.
    task automatic write_register(foe_cfg_idx_t idx, logic [CFG_W-1:0] value);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_FRAME_WIDTH:    width_reg  = value;
            CFG_FRAME_HEIGHT:   height_reg = value;
            CFG_TRANSFORM_MODE: mode_reg   = foe_mode_t'(value[1:0]);
            CFG_SWAP_CHANNELS:  swap_reg   = value[0];
            default:            ;
        endcase
    endtask

    function automatic void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %02h, got %02h", name, want_v, got_v);
            error_count++;
        end
    endfunction

    // Size set, mode and channel swap left at their reset values: a plain
    // copy with the first and third channels exchanged on load.
    task automatic test_reset_defaults();
        write_register(CFG_FRAME_WIDTH, CFG_W'(3));
        write_register(CFG_FRAME_HEIGHT, CFG_W'(2));
        send_load(8'h00, 8'h00, 8'h00);
        send_load(8'hFF, 8'hFF, 8'hFF);
        send_load(8'h01, 8'h02, 8'h03);
        send_load(8'hFF, 8'h00, 8'h80);
        send_load(8'h10, 8'h20, 8'h30);
        send_load(8'hAA, 8'h55, 8'h0F);
        repeat (6) send_fetch();
        phase_count++;
    endtask

    // Same 3x2 frame read back as a vertical flip, a mirror and a decimation.
    task automatic test_transform_modes();
        write_register(CFG_SWAP_CHANNELS, CFG_W'(0));
        send_load(8'h12, 8'h34, 8'h56);
        send_load(8'hFF, 8'h00, 8'hFF);
        send_load(8'h00, 8'hFF, 8'h00);
        send_load(8'h80, 8'h7F, 8'h01);
        send_load(8'hFE, 8'h01, 8'hC3);
        send_load(8'h3C, 8'hA5, 8'h5A);
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_VFLIP));
        repeat (6) send_fetch();
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_MIRROR));
        repeat (6) send_fetch();
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_DECIM));
        repeat (2) send_fetch();
        phase_count++;
    endtask

    // Counters left outside the frame by a register change, and a zero width.
    task automatic test_counter_limits();
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_MIRROR));
        // Three fetches leave the output counters at row 1, column 0.
        repeat (3) send_fetch();
        // Decimation makes the output one row high, so row 1 is outside it.
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_DECIM));
        repeat (2) send_fetch();
        send_load(8'h5A, 8'hC3, 8'h00);
        send_load(8'hFF, 8'h81, 8'h7E);
        // A width of zero acts as one: the frame is now two pixels and the
        // load position (two) is outside it.
        write_register(CFG_FRAME_WIDTH, CFG_W'(0));
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_COPY));
        send_load(8'h01, 8'hFE, 8'h80);
        send_load(8'h7F, 8'h00, 8'hFF);
        repeat (2) send_fetch();
        phase_count++;
    endtask

    // Receiver holds off while fetches keep coming, so the block backs up
    // and stalls its command channel.
    task automatic test_output_backpressure();
        write_register(CFG_FRAME_WIDTH, CFG_W'(4));
        write_register(CFG_FRAME_HEIGHT, CFG_W'(4));
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_VFLIP));
        write_register(CFG_SWAP_CHANNELS, CFG_W'(1));
        load_frame();
        wait_for_idle();
        rsp_hold_cycles = 150;
        repeat (24) send_fetch();
        phase_count++;
    endtask

    // Random phases: a size (mostly small, now and then the extremes), a
    // mode and a swap setting, a full frame load where needed and now and
    // then at random, then fetches with loads mixed in. Counters carry over
    // from phase to phase, so the register changes land mid-frame.
    task automatic test_random_frames(int unsigned goal);
        int unsigned start;
        int unsigned done;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned n;
        start = load_count + fetch_count;
        while (load_count + fetch_count - start < goal)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    w_raw = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(257, 511);
                    h_raw = $urandom_range(0, 2);
                end
                1:
                begin
                    h_raw = $urandom_range(0, 1) ? MAX_HEIGHT : $urandom_range(257, 511);
                    w_raw = $urandom_range(0, 2);
                end
                2:
                begin
                    w_raw = 0;
                    h_raw = $urandom_range(0, 3);
                end
                default:
                begin
                    w_raw = $urandom_range(1, 9);
                    h_raw = $urandom_range(1, 9);
                end
            endcase
            write_register(CFG_FRAME_WIDTH, CFG_W'(w_raw));
            write_register(CFG_FRAME_HEIGHT, CFG_W'(h_raw));
            // Upper data bits beyond the register width are don't-care.
            write_register(CFG_TRANSFORM_MODE,
                           CFG_W'(($urandom_range(0, 127) << 2) | $urandom_range(0, 3)));
            write_register(CFG_SWAP_CHANNELS,
                           CFG_W'(($urandom_range(0, 255) << 1) | $urandom_range(0, 1)));
            if (!frame_covered() || $urandom_range(0, 2) == 0)
            begin
                load_frame();
            end
            n = output_count() + $urandom_range(0, output_count());
            if (n > 600)
            begin
                n = 600;
            end
            // The last phase stops where the planned number of commands is reached.
            done = load_count + fetch_count - start;
            if (done >= goal)
            begin
                n = 0;
            end
            else if (n > goal - done)
            begin
                n = goal - done;
            end
            repeat (n)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    send_load(random_byte(), random_byte(), random_byte());
                end
                else
                begin
                    send_fetch();
                end
            end
            phase_count++;
        end
    endtask

    // Last part: no idling on either side, commands back to back.
    task automatic test_steady_stream();
        idle_enabled = 1'b0;
        write_register(CFG_FRAME_WIDTH, CFG_W'(7));
        write_register(CFG_FRAME_HEIGHT, CFG_W'(5));
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_DECIM));
        write_register(CFG_SWAP_CHANNELS, CFG_W'(1));
        load_frame();
        repeat (2 * output_count()) send_fetch();
        write_register(CFG_TRANSFORM_MODE, CFG_W'(MODE_MIRROR));
        repeat (output_count()) send_fetch();
        phase_count++;
    endtask

    // Response side: checks every transfer against the oldest owed pixel and
    // drives ready, with random stall bursts and the long hold-off on request.
    initial
    begin
        out_pixel_t  want;
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("output pixel %02h %02h %02h (frame_end %0b) with no fetch outstanding",
                           rsp_ch.out_first, rsp_ch.out_second, rsp_ch.out_third,
                           rsp_ch.frame_end);
                    error_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    compare_field("out_first", want.first, rsp_ch.out_first);
                    compare_field("out_second", want.second, rsp_ch.out_second);
                    compare_field("out_third", want.third, rsp_ch.out_third);
                    compare_field("frame_end", 8'(want.frame_end), 8'(rsp_ch.frame_end));
                    checked_count++;
                    if (want.frame_end)
                    begin
                        frame_end_count++;
                    end
                end
            end
            if (rsp_hold_cycles > 0)
            begin
                rsp_hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 7) == 0)
            begin
                // This cycle is the first of a stall burst; stall_left holds the rest.
                stall_left = $urandom_range(0, 12);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("frame_orientation_engine_core_tb failed");
        $finish;
    end

    initial
    begin
        int unsigned waited;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_LOAD;
        cmd_ch.in_first  = '0;
        cmd_ch.in_second = '0;
        cmd_ch.in_third  = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_FRAME_WIDTH;
        cfg_data         = '0;
        rst_n            = 1'b0;
        width_reg        = MAX_W_DIM;
        height_reg       = MAX_H_DIM;
        mode_reg         = MODE_COPY;
        swap_reg         = 1'b1;
        next_load_addr   = 0;
        next_out_row     = 0;
        next_out_col     = 0;
        error_count      = 0;
        load_count       = 0;
        fetch_count      = 0;
        checked_count    = 0;
        frame_end_count  = 0;
        phase_count      = 0;
        idle_enabled     = 1'b1;
        rsp_hold_cycles  = 0;
        waited           = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_transform_modes();
        test_counter_limits();
        test_output_backpressure();
        test_random_frames(RANDOM_ITEMS);
        test_steady_stream();

        // Let the block return what it still owes, then a few quiet cycles.
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected output pixels never came back", pending_pixels.size());
            error_count++;
        end

        $display("Covered %0d phases: %0d loads, %0d fetches, %0d pixels checked.",
                 phase_count, load_count, fetch_count, checked_count);
        $display("Saw %0d complete output frames; %0d errors.", frame_end_count, error_count);
        if (error_count == 0)
        begin
            $display("frame_orientation_engine_core_tb passed");
        end
        else
        begin
            $display("frame_orientation_engine_core_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/foe_pkg.sv
design/foe_cmd_if.sv
design/foe_rsp_if.sv
design/foe_frame_ram.sv
design/foe_sequencer.sv
design/frame_orientation_engine_core.sv
verif/frame_orientation_engine_core_tb.sv
